// ===== rtl/core/dpb_pkg.sv =====
package dpb_pkg;

    // fixed field widths
    localparam int DEPTH_W    = 16;
    localparam int DIM_W      = 13;
    localparam int CENTER_W   = 16;
    localparam int RECIP_W    = 24;
    localparam int COORD_W    = 28;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // offset magnitude |pos*16 - center| over the whole dimension range
    localparam int MAG_W = 18;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_CENTER_X     = 3'd2,
        CFG_CENTER_Y     = 3'd3,
        CFG_INV_FOCAL_X  = 3'd4,
        CFG_INV_FOCAL_Y  = 3'd5
    } cfg_index_t;

    // input word
    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic               depth_valid;
        logic               frame_start;
    } pixel_t;

    // result word
    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [DEPTH_W-1:0]        point_z;
        logic                      point_valid;
        logic                      last_point;
    } point_t;

    // classified pixel handed from front to back
    typedef struct packed {
        logic [MAG_W-1:0]   mag_x;
        logic               neg_x;
        logic [MAG_W-1:0]   mag_y;
        logic               neg_y;
        logic [DEPTH_W-1:0] depth;
        logic               depth_valid;
        logic               last;
    } job_t;

endpackage

// ===== rtl/core/dpb_front.sv =====
module dpb_front #(
    parameter int MAX_DIM    = 4096,
    parameter int DEPTH_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         take,
    input  dpb_pkg::pixel_t              pixel,
    input  logic [dpb_pkg::DIM_W-1:0]    image_width,
    input  logic [dpb_pkg::DIM_W-1:0]    image_height,
    input  logic [dpb_pkg::CENTER_W-1:0] center_x,
    input  logic [dpb_pkg::CENTER_W-1:0] center_y,
    output dpb_pkg::job_t                job,
    output logic                         job_push
);

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int DC_W  = (CNT_W + 1 > dpb_pkg::DIM_W) ? CNT_W + 1 : dpb_pkg::DIM_W;
    localparam int ZW    = (DEPTH_BITS < dpb_pkg::DEPTH_W) ? DEPTH_BITS : dpb_pkg::DEPTH_W;
    localparam int DL_W  = dpb_pkg::MAG_W + 1;
    localparam logic [DC_W-1:0] MAX_DIM_C = DC_W'(MAX_DIM);

    logic [CNT_W-1:0] col_reg, col_next, row_reg, row_next;
    logic [CNT_W-1:0] col_cur, row_cur;
    logic [DC_W-1:0]  w_eff, h_eff;
    logic             active, col_end, row_end;
    logic signed [DL_W-1:0] delta_x, delta_y;
    logic [dpb_pkg::MAG_W-1:0] mag_x, mag_y;

    // effective frame size, oversized values act as the maximum
    always_comb
    begin
        w_eff = (DC_W'(image_width) > MAX_DIM_C) ? MAX_DIM_C : DC_W'(image_width);
        h_eff = (DC_W'(image_height) > MAX_DIM_C) ? MAX_DIM_C : DC_W'(image_height);
        active = (w_eff != '0) && (h_eff != '0);
    end

    // position of this pixel, frame start restarts at the origin
    assign col_cur = pixel.frame_start ? '0 : col_reg;
    assign row_cur = pixel.frame_start ? '0 : row_reg;
    assign col_end = DC_W'(col_cur) >= (w_eff - DC_W'(1));
    assign row_end = DC_W'(row_cur) >= (h_eff - DC_W'(1));

    // signed offset from the principal point in q.4, split into sign and magnitude
    always_comb
    begin
        delta_x = DL_W'({col_cur, 4'b0000}) - DL_W'(center_x);
        delta_y = DL_W'({row_cur, 4'b0000}) - DL_W'(center_y);
        mag_x   = delta_x[DL_W-1] ? dpb_pkg::MAG_W'(-delta_x) : dpb_pkg::MAG_W'(delta_x);
        mag_y   = delta_y[DL_W-1] ? dpb_pkg::MAG_W'(-delta_y) : dpb_pkg::MAG_W'(delta_y);
    end

    // job word, an invalid sample carries zero magnitudes and depth
    always_comb
    begin
        job.mag_x       = pixel.depth_valid ? mag_x : '0;
        job.neg_x       = pixel.depth_valid & delta_x[DL_W-1];
        job.mag_y       = pixel.depth_valid ? mag_y : '0;
        job.neg_y       = pixel.depth_valid & delta_y[DL_W-1];
        job.depth       = pixel.depth_valid ?
                          dpb_pkg::DEPTH_W'(pixel.depth[ZW-1:0]) : '0;
        job.depth_valid = pixel.depth_valid;
        job.last        = col_end & row_end;
        job_push        = take & active;
    end

    // raster counters
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (take)
        begin
            col_next = col_cur;
            row_next = row_cur;
            if (active)
            begin
                if (col_end)
                begin
                    col_next = '0;
                    row_next = row_end ? '0 : row_cur + CNT_W'(1);
                end
                else
                begin
                    col_next = col_cur + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== rtl/core/dpb_queue.sv =====
module dpb_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dpb_pkg::job_t wr_job,
    output logic          full,
    input  logic          take,
    output logic          avail,
    output dpb_pkg::job_t rd_job
);

    localparam int ENTRIES = 2;
    localparam int PTR_W   = $clog2(ENTRIES);

    dpb_pkg::job_t    store_reg [ENTRIES];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_push, do_take;

    assign full    = count_reg == (PTR_W+1)'(ENTRIES);
    assign avail   = count_reg != '0;
    assign do_push = push & ~full;
    assign do_take = take & avail;
    assign rd_job  = store_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_take)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_take)
            begin
                count_reg <= count_reg + (PTR_W+1)'(1);
            end
            else if (do_take && !do_push)
            begin
                count_reg <= count_reg - (PTR_W+1)'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

// ===== rtl/core/dpb_back.sv =====
module dpb_back #(
    parameter int RECIP_FRAC_BITS = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        job_avail,
    input  dpb_pkg::job_t               job,
    output logic                        job_take,
    input  logic [dpb_pkg::RECIP_W-1:0] inv_focal_x,
    input  logic [dpb_pkg::RECIP_W-1:0] inv_focal_y,
    output dpb_pkg::point_t             point,
    output logic                        empty,
    input  logic                        pop
);

    localparam int MZ_W  = dpb_pkg::MAG_W + dpb_pkg::DEPTH_W;
    localparam int P_W   = MZ_W + dpb_pkg::RECIP_W;
    localparam int S_W   = P_W + 1;
    localparam logic [S_W-1:0] HALF    = S_W'(1) << (RECIP_FRAC_BITS - 1);
    localparam logic [S_W-1:0] SAT_POS = S_W'(134217727);
    localparam logic [S_W-1:0] SAT_NEG = S_W'(134217728);

    // stage 1: offset times depth
    logic                        v1_reg;
    logic [MZ_W-1:0]             mzx1_reg, mzy1_reg;
    logic                        negx1_reg, negy1_reg, valid1_reg, last1_reg;
    logic [dpb_pkg::DEPTH_W-1:0] z1_reg;

    // stage 2: times reciprocal focal length
    logic                        v2_reg;
    logic [P_W-1:0]              px2_reg, py2_reg;
    logic                        negx2_reg, negy2_reg, valid2_reg, last2_reg;
    logic [dpb_pkg::DEPTH_W-1:0] z2_reg;

    // stage 3: rounded, saturated result word
    logic                        v3_reg;
    dpb_pkg::point_t             out_reg;

    logic rdy1, rdy2, rdy3;

    // drop the fraction bits, round half away from zero, clamp, apply sign
    function automatic logic [dpb_pkg::COORD_W-1:0] round_sat(
        input logic [P_W-1:0] prod,
        input logic           neg
    );
        logic [S_W-1:0]              r;
        logic [dpb_pkg::COORD_W-1:0] mag;
        r = ({1'b0, prod} + HALF) >> RECIP_FRAC_BITS;
        if (neg)
        begin
            if (r > SAT_NEG)
            begin
                r = SAT_NEG;
            end
        end
        else if (r > SAT_POS)
        begin
            r = SAT_POS;
        end
        mag = r[dpb_pkg::COORD_W-1:0];
        return neg ? dpb_pkg::COORD_W'(-mag) : mag;
    endfunction

    // stall chain from the result side back to the queue
    assign rdy3     = ~v3_reg | pop;
    assign rdy2     = ~v2_reg | rdy3;
    assign rdy1     = ~v1_reg | rdy2;
    assign job_take = job_avail & rdy1;
    assign empty    = ~v3_reg;
    assign point    = out_reg;

    // stage occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= job_avail;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            mzx1_reg   <= MZ_W'(job.mag_x) * MZ_W'(job.depth);
            mzy1_reg   <= MZ_W'(job.mag_y) * MZ_W'(job.depth);
            negx1_reg  <= job.neg_x;
            negy1_reg  <= job.neg_y;
            z1_reg     <= job.depth;
            valid1_reg <= job.depth_valid;
            last1_reg  <= job.last;
        end
        if (rdy2 && v1_reg)
        begin
            px2_reg    <= P_W'(mzx1_reg) * P_W'(inv_focal_x);
            py2_reg    <= P_W'(mzy1_reg) * P_W'(inv_focal_y);
            negx2_reg  <= negx1_reg;
            negy2_reg  <= negy1_reg;
            z2_reg     <= z1_reg;
            valid2_reg <= valid1_reg;
            last2_reg  <= last1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            out_reg.point_x     <= round_sat(px2_reg, negx2_reg);
            out_reg.point_y     <= round_sat(py2_reg, negy2_reg);
            out_reg.point_z     <= z2_reg;
            out_reg.point_valid <= valid2_reg;
            out_reg.last_point  <= last2_reg;
        end
    end

endmodule

// ===== rtl/core/depth_pixel_backprojection_core.sv =====
// Pinhole back-projection of a raster depth stream. Each pushed depth word is
// placed at the current column and row (frame_start restarts at the origin),
// and yields one point word with x = (col - cx) * z / fx and y = (row - cy) *
// z / fy in depth units with 4 fraction bits, rounded half away from zero and
// saturated to 28 bits signed; invalid depth gives zeros with point_valid low.
// While image_width or image_height is zero no point words are produced.
// The block sustains one pixel per clock while pop keeps up: a two-entry
// queue sits between the position counters and a three-stage multiply,
// round and saturate pipeline, through which each pushed pixel passes to
// the result side. Registers are written on the cfg channel, which is always
// ready, and should only be changed while no pixel is in flight.
module depth_pixel_backprojection_core #(
    parameter int MAX_DIM         = 4096,
    parameter int DEPTH_BITS      = 16,
    parameter int RECIP_FRAC_BITS = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  dpb_pkg::pixel_t                pixel,
    output logic                           empty,
    input  logic                           pop,
    output dpb_pkg::point_t                point,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dpb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dpb_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic [dpb_pkg::DIM_W-1:0]    image_width_reg, image_height_reg;
    logic [dpb_pkg::CENTER_W-1:0] center_x_reg, center_y_reg;
    logic [dpb_pkg::RECIP_W-1:0]  inv_focal_x_reg, inv_focal_y_reg;

    logic          take;
    logic          job_push, job_avail, job_take;
    dpb_pkg::job_t front_job, queue_job;

    assign cfg_ready = 1'b1;
    assign take      = push & ~full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= '0;
            image_height_reg <= '0;
            center_x_reg     <= '0;
            center_y_reg     <= '0;
            inv_focal_x_reg  <= '0;
            inv_focal_y_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (dpb_pkg::cfg_index_t'(cfg_index))
                dpb_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[dpb_pkg::DIM_W-1:0];
                dpb_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[dpb_pkg::DIM_W-1:0];
                dpb_pkg::CFG_CENTER_X:     center_x_reg     <= cfg_data[dpb_pkg::CENTER_W-1:0];
                dpb_pkg::CFG_CENTER_Y:     center_y_reg     <= cfg_data[dpb_pkg::CENTER_W-1:0];
                dpb_pkg::CFG_INV_FOCAL_X:  inv_focal_x_reg  <= cfg_data[dpb_pkg::RECIP_W-1:0];
                dpb_pkg::CFG_INV_FOCAL_Y:  inv_focal_y_reg  <= cfg_data[dpb_pkg::RECIP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // position tracking and classification
    dpb_front #(
        .MAX_DIM    (MAX_DIM),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .pixel        (pixel),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .center_x     (center_x_reg),
        .center_y     (center_y_reg),
        .job          (front_job),
        .job_push     (job_push)
    );

    // decoupling queue
    dpb_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (job_push),
        .wr_job (front_job),
        .full   (full),
        .take   (job_take),
        .avail  (job_avail),
        .rd_job (queue_job)
    );

    // multiply, round and saturate
    dpb_back #(
        .RECIP_FRAC_BITS (RECIP_FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_avail   (job_avail),
        .job         (queue_job),
        .job_take    (job_take),
        .inv_focal_x (inv_focal_x_reg),
        .inv_focal_y (inv_focal_y_reg),
        .point       (point),
        .empty       (empty),
        .pop         (pop)
    );

endmodule

// ===== tb/sv/depth_pixel_backprojection_tb_pkg.sv =====
package depth_pixel_backprojection_tb_pkg;

    import dpb_pkg::*;

    // dimension registers above this act as this
    localparam int unsigned DIM_LIMIT = 4096;
    localparam int FRAC_BITS = 24;
    localparam longint unsigned SAT_POS = (64'd1 << (COORD_W - 1)) - 64'd1;
    localparam longint unsigned SAT_NEG = 64'd1 << (COORD_W - 1);

    class point_scoreboard;
        // register copies
        bit [DIM_W-1:0]    image_width;
        bit [DIM_W-1:0]    image_height;
        bit [CENTER_W-1:0] center_x;
        bit [CENTER_W-1:0] center_y;
        bit [RECIP_W-1:0]  inv_focal_x;
        bit [RECIP_W-1:0]  inv_focal_y;

        // raster position
        bit [11:0] column_pos;
        bit [11:0] row_pos;

        point_t expected_points[$];
        int     mismatches;

        function void write_register(cfg_index_t idx, bit [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_IMAGE_WIDTH:  image_width  = data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: image_height = data[DIM_W-1:0];
                CFG_CENTER_X:     center_x     = data[CENTER_W-1:0];
                CFG_CENTER_Y:     center_y     = data[CENTER_W-1:0];
                CFG_INV_FOCAL_X:  inv_focal_x  = data[RECIP_W-1:0];
                CFG_INV_FOCAL_Y:  inv_focal_y  = data[RECIP_W-1:0];
                default: ;
            endcase
        endfunction

        // (pos*16 - centre) * z * recip, rounded half away from zero, saturated
        function bit [COORD_W-1:0] project_axis(bit [11:0] pos, bit [CENTER_W-1:0] centre,
                                                bit [DEPTH_W-1:0] z, bit [RECIP_W-1:0] recip);
            longint signed   offset;
            longint unsigned magnitude;
            longint unsigned product;
            longint unsigned rounded;
            bit              negative;
            offset    = longint'({pos, 4'b0000}) - longint'(centre);
            negative  = offset < 0;
            magnitude = negative ? -offset : offset;
            product   = magnitude * 64'(z) * 64'(recip);
            rounded   = (product + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            if (negative) begin
                if (rounded > SAT_NEG)
                    rounded = SAT_NEG;
                rounded = -rounded;
            end
            else if (rounded > SAT_POS) begin
                rounded = SAT_POS;
            end
            return rounded[COORD_W-1:0];
        endfunction

        function void note_pixel(pixel_t px);
            int unsigned w_eff;
            int unsigned h_eff;
            bit          col_end;
            bit          row_end;
            point_t      p;
            w_eff = (image_width > DIM_LIMIT) ? DIM_LIMIT : image_width;
            h_eff = (image_height > DIM_LIMIT) ? DIM_LIMIT : image_height;
            if (px.frame_start) begin
                column_pos = '0;
                row_pos    = '0;
            end
            // output disabled: position held
            if (w_eff == 0 || h_eff == 0)
                return;
            col_end = column_pos >= w_eff - 1;
            row_end = row_pos >= h_eff - 1;
            p = '0;
            if (px.depth_valid) begin
                p.point_x     = project_axis(column_pos, center_x, px.depth, inv_focal_x);
                p.point_y     = project_axis(row_pos, center_y, px.depth, inv_focal_y);
                p.point_z     = px.depth;
                p.point_valid = 1'b1;
            end
            p.last_point = col_end && row_end;
            expected_points.push_back(p);
            // advance, wrapping anything past the last column or row
            if (col_end) begin
                column_pos = '0;
                row_pos    = row_end ? 12'd0 : row_pos + 12'd1;
            end
            else begin
                column_pos = column_pos + 12'd1;
            end
        endfunction

        function void compare_field(string name, logic signed [63:0] want,
                                    logic signed [63:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_point(point_t got);
            point_t want;
            if (expected_points.size() == 0) begin
                $error("point word with none expected: x %0d y %0d z %0d",
                       got.point_x, got.point_y, got.point_z);
                mismatches++;
                return;
            end
            want = expected_points.pop_front();
            compare_field("point_x", want.point_x, got.point_x);
            compare_field("point_y", want.point_y, got.point_y);
            compare_field("point_z", want.point_z, got.point_z);
            compare_field("point_valid", want.point_valid, got.point_valid);
            compare_field("last_point", want.last_point, got.last_point);
        endfunction

        function int outstanding();
            return expected_points.size();
        endfunction

        function void flag_leftovers();
            if (expected_points.size() != 0) begin
                $error("%0d point words never arrived", expected_points.size());
                mismatches++;
            end
        endfunction
    endclass

endpackage

// ===== tb/sv/depth_pixel_backprojection_core_tb.sv =====
module depth_pixel_backprojection_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dpb_pkg::*;
    import depth_pixel_backprojection_tb_pkg::*;

    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_ITEMS  = 1800;

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    pixel_t                pixel;
    logic                  empty;
    logic                  pop;
    point_t                point;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    point_scoreboard sb = new();

    bit sender_eager;
    bit receiver_eager;
    int hold_cycles;

    depth_pixel_backprojection_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pixel     (pixel),
        .empty     (empty),
        .pop       (pop),
        .point     (point),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int draw_gap(bit eager);
        return eager ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic pixel_t make_pixel(bit [DEPTH_W-1:0] depth, bit valid, bit start);
        pixel_t px;
        px.depth       = depth;
        px.depth_valid = valid;
        px.frame_start = start;
        return px;
    endfunction

    function automatic bit [DEPTH_W-1:0] random_depth();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return DEPTH_W'($urandom);
        endcase
    endfunction

    function automatic bit [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return 13'd1;
            2: return 13'd4096;
            3: return 13'd8191;
            4: return 13'($urandom_range(4097, 8191));
            5, 6: return 13'($urandom_range(17, 300));
            default: return 13'($urandom_range(2, 16));
        endcase
    endfunction

    function automatic bit [CENTER_W-1:0] pick_centre();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3: return 16'($urandom_range(0, 512));
            default: return CENTER_W'($urandom);
        endcase
    endfunction

    function automatic bit [RECIP_W-1:0] pick_recip();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 24'h800000;
            3, 4: return 24'($urandom_range(24'h004000, 24'h020000));
            default: return RECIP_W'($urandom);
        endcase
    endfunction

    // write all six registers back to back; pad puts junk above the field widths
    task automatic configure(bit [DIM_W-1:0] w, bit [DIM_W-1:0] h,
                             bit [CENTER_W-1:0] cx, bit [CENTER_W-1:0] cy,
                             bit [RECIP_W-1:0] fx, bit [RECIP_W-1:0] fy, bit pad);
        cfg_index_t            regs [6];
        bit [CFG_DATA_W-1:0]   words [6];
        regs = '{CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_CENTER_X, CFG_CENTER_Y,
                 CFG_INV_FOCAL_X, CFG_INV_FOCAL_Y};
        words[0] = {pad ? 11'($urandom) : 11'd0, w};
        words[1] = {pad ? 11'($urandom) : 11'd0, h};
        words[2] = {pad ? 8'($urandom) : 8'd0, cx};
        words[3] = {pad ? 8'($urandom) : 8'd0, cy};
        words[4] = fx;
        words[5] = fy;
        for (int i = 0; i < 6; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= words[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            sb.write_register(regs[i], words[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // offer one pixel word and hold it until taken
    task automatic send_pixel(pixel_t px);
        int gap;
        gap = draw_gap(sender_eager);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push  <= 1'b1;
        pixel <= px;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_pixel(px);
    endtask

    // let every expected point word out, then let the pipeline empty
    task automatic settle();
        push <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mostly well-formed frames with random content; noise flips frame_start
    task automatic run_frames(int n_items, bit noisy, inout int counted);
        int unsigned w_eff;
        int unsigned h_eff;
        int          frame_len;
        int          in_frame;
        pixel_t      px;
        w_eff     = (sb.image_width > DIM_LIMIT) ? DIM_LIMIT : sb.image_width;
        h_eff     = (sb.image_height > DIM_LIMIT) ? DIM_LIMIT : sb.image_height;
        frame_len = w_eff * h_eff;
        in_frame  = 0;
        sender_eager   = ($urandom_range(0, 3) == 0);
        receiver_eager = ($urandom_range(0, 3) == 0);
        repeat (n_items) begin
            px.depth       = random_depth();
            px.depth_valid = ($urandom_range(0, 7) != 0);
            px.frame_start = (in_frame == 0);
            if (noisy && $urandom_range(0, 19) == 0)
                px.frame_start = !px.frame_start;
            send_pixel(px);
            in_frame = px.frame_start ? 1 : in_frame + 1;
            if (in_frame >= frame_len)
                in_frame = 0;
            if (frame_len != 0)
                counted++;
        end
        settle();
    endtask

    // result side: random pop gaps, plus one long hold on request
    initial
    begin : result_drain
        int gap;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_cycles > 0) begin
                pop <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            gap = draw_gap(receiver_eager);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            sb.check_point(point);
        end
    end

    initial
    begin : stimulus
        int counted;
        int phase;
        rst_n     <= 1'b0;
        push      <= 1'b0;
        pixel     <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // output disabled straight after reset
        send_pixel(make_pixel(16'hFFFF, 1'b1, 1'b1));
        send_pixel(make_pixel(16'h0001, 1'b1, 1'b0));
        send_pixel(make_pixel(16'h8000, 1'b0, 1'b1));
        settle();

        // small frame: rounding tie, negative saturation, zero and invalid depth,
        // last pixel, wrap to origin, restart mid-frame
        configure(13'd3, 13'd2, 16'd1, 16'hFFFF, 24'h800000, 24'hFFFFFF, 1'b0);
        send_pixel(make_pixel(16'd1, 1'b1, 1'b1));
        send_pixel(make_pixel(16'hFFFF, 1'b1, 1'b0));
        send_pixel(make_pixel(16'd0, 1'b1, 1'b0));
        send_pixel(make_pixel(16'hFFFF, 1'b0, 1'b0));
        send_pixel(make_pixel(16'h5A5A, 1'b1, 1'b0));
        send_pixel(make_pixel(16'hA5A5, 1'b1, 1'b0));
        send_pixel(make_pixel(16'hFFFF, 1'b1, 1'b0));
        send_pixel(make_pixel(16'd7, 1'b1, 1'b1));
        send_pixel(make_pixel(16'hFFFF, 1'b1, 1'b0));
        settle();

        // shrink the image while mid-frame so the position is out of range
        configure(13'd5, 13'd5, 16'd0, 16'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
        send_pixel(make_pixel(16'hFFFF, 1'b1, 1'b1));
        repeat (7) send_pixel(make_pixel(random_depth(), 1'b1, 1'b0));
        settle();
        configure(13'd2, 13'd1, 16'hFFFF, 16'd0, 24'h000001, 24'h000000, 1'b1);
        send_pixel(make_pixel(16'hFFFF, 1'b1, 1'b0));
        send_pixel(make_pixel(16'hFFFF, 1'b1, 1'b0));
        settle();

        // oversized dimensions act as the largest
        configure(13'd8191, 13'd8191, 16'h8000, 16'h8000, 24'h000000, 24'h123456, 1'b1);
        send_pixel(make_pixel(16'hFFFF, 1'b1, 1'b1));
        send_pixel(make_pixel(16'h1234, 1'b1, 1'b0));
        send_pixel(make_pixel(16'h0000, 1'b0, 1'b0));
        settle();

        counted = 0;
        // single tall column: rows climb far enough to saturate y upwards
        configure(13'd1, 13'd4096, 16'd0, 16'd0, pick_recip(), 24'hFFFFFF, 1'b1);
        run_frames(300, 1'b0, counted);
        // single long row: columns climb far enough to saturate x upwards
        configure(13'd4096, 13'd1, 16'd0, 16'd0, 24'hFFFFFF, pick_recip(), 1'b0);
        run_frames(300, 1'b0, counted);

        phase = 0;
        while (counted < RANDOM_ITEMS) begin
            configure(pick_dim(), pick_dim(), pick_centre(), pick_centre(),
                      pick_recip(), pick_recip(), $urandom_range(0, 1));
            // result side holds off while pixels keep coming, so the block fills
            if (phase == 2 || phase == 7)
                hold_cycles = 400;
            run_frames($urandom_range(60, 160), 1'b1, counted);
            phase++;
        end

        settle();
        sb.flag_leftovers();
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // run limit
    initial
    begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
